// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL; only turing_machine_step_top includes them.
// Both forms are disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tms_pkg.sv -----
package tms_pkg;

  // Tape and rule table sizing.
  localparam int TAPE_LEN    = 256;
  localparam int MAX_STATES  = 16;
  localparam int MAX_SYMBOLS = 16;
  localparam int RULE_DEPTH  = MAX_STATES * MAX_SYMBOLS;

  localparam int POS_W  = $clog2(TAPE_LEN);
  localparam int RIDX_W = $clog2(RULE_DEPTH);

  // Field widths of the request and result ports.
  localparam int KIND_W   = 2;
  localparam int SYM_W    = 4;
  localparam int ST_W     = 4;
  localparam int MOVE_W   = 2;
  localparam int NS_W     = 5;
  localparam int OPOS_W   = 8;
  localparam int OIDX_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  // Width of the rule index before it is folded onto the table depth.
  localparam int IDX_FULL_W = SYM_W + NS_W + 1;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Head move codes; the unused code behaves as stay.
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_CYCLE = 1'd1;

  // Head and extent values after a tape clear.
  localparam logic [POS_W-1:0] HEAD_INIT  = POS_W'(TAPE_LEN / 2);
  localparam logic [POS_W-1:0] LEFT_INIT  = POS_W'(TAPE_LEN / 2 - 1);
  localparam logic [POS_W-1:0] RIGHT_INIT = POS_W'(TAPE_LEN / 2 + 1);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(TAPE_LEN - 1);

  // Operation applied to every tape cell at once.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             wr_en;
    logic [SYM_W-1:0] wr_sym;
  } cell_ctrl_t;

  // One rule table entry.
  typedef struct packed {
    logic [SYM_W-1:0]  wr_sym;
    logic [MOVE_W-1:0] move;
    logic [ST_W-1:0]   next_st;
  } rule_t;

endpackage

// ----- rtl/core/turing_machine_step_top.sv -----
// Channel  | Direction | Handshake           | Payload
// in_      | request   | in_valid/in_ready   | kind, rule fields
// out_     | result    | out_valid/out_ready | step result fields
// cfg_     | write     | cfg_we              | cfg_index, cfg_data
//
// A load or clear request completes when it is accepted; a step request goes through
// the registered rule table read, then the apply cycle that writes the tape.
// One request is in work at a time: in_ready is high only while the sequencer is idle.
// The apply cycle waits while the result register is full and not taken.
// Synchronous reset clears all tape cells at once; the rule table is not
// cleared and holds whatever was loaded.
`include "assert_macros.svh"

module turing_machine_step_top
  import tms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [SYM_W-1:0]     in_rule_symbol,
  input  logic [ST_W-1:0]      in_rule_state,
  input  logic [SYM_W-1:0]     in_rule_write,
  input  logic [MOVE_W-1:0]    in_rule_move,
  input  logic [ST_W-1:0]      in_rule_next,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SYM_W-1:0]     out_read_symbol,
  output logic [SYM_W-1:0]     out_written_symbol,
  output logic [OPOS_W-1:0]    out_prior_position,
  output logic                 out_extended_right,
  output logic                 out_extended_left,
  output logic [OIDX_W-1:0]    out_rule_index,
  output logic [ST_W-1:0]      out_new_state,
  output logic                 out_tape_edge,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } fsm_t;

  fsm_t              state_r, state_nxt;
  logic [POS_W-1:0]  head_r, head_nxt;
  logic [POS_W-1:0]  left_r, left_nxt;
  logic [POS_W-1:0]  right_r, right_nxt;
  logic [ST_W-1:0]   mstate_r, mstate_nxt;
  logic [NS_W-1:0]   num_states_r, num_states_nxt;
  logic              detect_r, detect_nxt;
  logic [SYM_W-1:0]  rd_sym_r, rd_sym_nxt;
  logic [RIDX_W-1:0] ridx_r, ridx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  o_read_r, o_read_nxt;
  logic [SYM_W-1:0]  o_written_r, o_written_nxt;
  logic [OPOS_W-1:0] o_pos_r, o_pos_nxt;
  logic              o_ext_r_r, o_ext_r_nxt;
  logic              o_ext_l_r, o_ext_l_nxt;
  logic [OIDX_W-1:0] o_ridx_r, o_ridx_nxt;
  logic [ST_W-1:0]   o_state_r, o_state_nxt;
  logic              o_edge_r, o_edge_nxt;

  rule_t             rule_mem [RULE_DEPTH];
  rule_t             rule_q_r;

  logic              accept;
  logic              out_free;
  logic              commit;
  logic [SYM_W-1:0]  head_sym;
  logic [RIDX_W-1:0] look_idx;
  logic [RIDX_W-1:0] load_idx;
  logic [POS_W-1:0]  new_pos;
  logic              edge_hit;
  cell_op_t          move_op;
  cell_ctrl_t        cell_ctrl;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_APPLY) && out_free;

  // Rule index: symbol times state count plus state, modulo the table depth.
  assign look_idx = RIDX_W'(IDX_FULL_W'(head_sym) * IDX_FULL_W'(num_states_r)
                            + IDX_FULL_W'(mstate_r));
  assign load_idx = RIDX_W'(IDX_FULL_W'(in_rule_symbol) * IDX_FULL_W'(num_states_r)
                            + IDX_FULL_W'(in_rule_state));

  // Rule table: written by load requests, read once per step request.
  always_ff @(posedge clk) begin
    if (accept && (in_kind == KIND_LOAD)) begin
      rule_mem[load_idx] <= '{wr_sym: in_rule_write, move: in_rule_move,
                              next_st: in_rule_next};
    end
    if (accept && (in_kind == KIND_STEP)) begin
      rule_q_r <= rule_mem[look_idx];
    end
  end

  // Head move with clipping at both tape ends.
  always_comb begin
    new_pos  = head_r;
    edge_hit = 1'b0;
    move_op  = CELL_HOLD;
    case (rule_q_r.move)
      MOVE_LEFT: begin
        if (head_r == '0) begin
          edge_hit = 1'b1;
        end else begin
          new_pos = head_r - POS_W'(1);
          move_op = CELL_TAKE_LEFT;
        end
      end
      MOVE_RIGHT: begin
        if (head_r == POS_LAST) begin
          edge_hit = 1'b1;
        end else begin
          new_pos = head_r + POS_W'(1);
          move_op = CELL_TAKE_RIGHT;
        end
      end
      default: begin
        new_pos = head_r;
      end
    endcase
  end

  // Control for the whole row of tape cells.
  always_comb begin
    cell_ctrl.wr_en  = commit;
    cell_ctrl.wr_sym = rule_q_r.wr_sym;
    if (commit) begin
      cell_ctrl.op = move_op;
    end else if (accept && (in_kind == KIND_CLEAR)) begin
      cell_ctrl.op = CELL_CLEAR;
    end else begin
      cell_ctrl.op = CELL_HOLD;
    end
  end

  tms_tape u_tape (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (cell_ctrl),
    .head_sym_o (head_sym)
  );

  // Next-state logic for the sequencer, head, extents and result register.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    mstate_nxt     = mstate_r;
    num_states_nxt = num_states_r;
    detect_nxt     = detect_r;
    rd_sym_nxt     = rd_sym_r;
    ridx_nxt       = ridx_r;
    out_valid_nxt  = out_valid_r;
    o_read_nxt     = o_read_r;
    o_written_nxt  = o_written_r;
    o_pos_nxt      = o_pos_r;
    o_ext_r_nxt    = o_ext_r_r;
    o_ext_l_nxt    = o_ext_l_r;
    o_ridx_nxt     = o_ridx_r;
    o_state_nxt    = o_state_r;
    o_edge_nxt     = o_edge_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_STATES:   num_states_nxt = cfg_data[NS_W-1:0];
        CFG_DETECT_CYCLE: detect_nxt = cfg_data[0];
        default:          ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_STEP: begin
              rd_sym_nxt = head_sym;
              ridx_nxt   = look_idx;
              state_nxt  = ST_APPLY;
            end
            KIND_CLEAR: begin
              head_nxt   = HEAD_INIT;
              left_nxt   = LEFT_INIT;
              right_nxt  = RIGHT_INIT;
              mstate_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_APPLY: begin
        if (commit) begin
          head_nxt    = new_pos;
          mstate_nxt  = rule_q_r.next_st;
          o_ext_r_nxt = 1'b0;
          o_ext_l_nxt = 1'b0;
          if (new_pos >= right_r) begin
            right_nxt   = (new_pos == POS_LAST) ? POS_LAST : new_pos + POS_W'(1);
            o_ext_r_nxt = 1'b1;
          end else if (new_pos <= left_r) begin
            left_nxt    = (new_pos == '0) ? '0 : new_pos - POS_W'(1);
            o_ext_l_nxt = 1'b1;
          end
          out_valid_nxt = 1'b1;
          o_read_nxt    = rd_sym_r;
          o_written_nxt = rule_q_r.wr_sym;
          o_pos_nxt     = OPOS_W'(head_r);
          o_ridx_nxt    = detect_r ? OIDX_W'(ridx_r) : '0;
          o_state_nxt   = rule_q_r.next_st;
          o_edge_nxt    = edge_hit;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer state, machine state and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= HEAD_INIT;
      left_r       <= LEFT_INIT;
      right_r      <= RIGHT_INIT;
      mstate_r     <= '0;
      num_states_r <= NS_W'(1);
      detect_r     <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      mstate_r     <= mstate_nxt;
      num_states_r <= num_states_nxt;
      detect_r     <= detect_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    rd_sym_r    <= rd_sym_nxt;
    ridx_r      <= ridx_nxt;
    o_read_r    <= o_read_nxt;
    o_written_r <= o_written_nxt;
    o_pos_r     <= o_pos_nxt;
    o_ext_r_r   <= o_ext_r_nxt;
    o_ext_l_r   <= o_ext_l_nxt;
    o_ridx_r    <= o_ridx_nxt;
    o_state_r   <= o_state_nxt;
    o_edge_r    <= o_edge_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_symbol    = o_read_r;
  assign out_written_symbol = o_written_r;
  assign out_prior_position = o_pos_r;
  assign out_extended_right = o_ext_r_r;
  assign out_extended_left  = o_ext_l_r;
  assign out_rule_index     = o_ridx_r;
  assign out_new_state      = o_state_r;
  assign out_tape_edge      = o_edge_r;

  // Only the apply cycle may raise a result.
  `ASSERT_NEXT(a_result_from_apply, clk, rst_n, (state_r == ST_IDLE) && !out_valid_r, !out_valid_r, "result raised outside the apply cycle")
  // A held result stalls the apply cycle.
  `ASSERT_NEXT(a_apply_stalls, clk, rst_n, (state_r == ST_APPLY) && out_valid_r && !out_ready, (state_r == ST_APPLY) && out_valid_r, "apply cycle went ahead over a held result")
  // A clipped move leaves the head where it was.
  `ASSERT_NEXT(a_edge_holds_head, clk, rst_n, commit && edge_hit, head_r == $past(head_r), "head moved on a clipped step")
  // The head stays strictly inside the written extents except at the tape ends.
  `ASSERT_SAME(a_extents_order, clk, rst_n, state_r == ST_IDLE, ((left_r < head_r) || (left_r == '0)) && ((head_r < right_r) || (right_r == POS_LAST)), "head outside its extents")

endmodule

// ----- rtl/core/tms_cell.sv -----
module tms_cell
  import tms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl_i,
  input  logic             is_head_i,
  input  logic [SYM_W-1:0] from_left_i,
  input  logic [SYM_W-1:0] from_right_i,
  output logic [SYM_W-1:0] sym_o
);

  logic [SYM_W-1:0] sym_r;
  logic [SYM_W-1:0] sym_nxt;

  // The head cell shows the rule's symbol while it is being written, so the
  // written value travels with the shift in the same cycle.
  assign sym_o = (is_head_i && ctrl_i.wr_en) ? ctrl_i.wr_sym : sym_r;

  // Next symbol: hold (with the head write), take a neighbour, or clear.
  always_comb begin
    case (ctrl_i.op)
      CELL_CLEAR:      sym_nxt = '0;
      CELL_TAKE_LEFT:  sym_nxt = from_left_i;
      CELL_TAKE_RIGHT: sym_nxt = from_right_i;
      default:         sym_nxt = sym_o;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= '0;
    end else begin
      sym_r <= sym_nxt;
    end
  end

endmodule

// ----- rtl/core/tms_tape.sv -----
module tms_tape
  import tms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl_i,
  output logic [SYM_W-1:0] head_sym_o
);

  // The tape is a ring of cells. Cell zero always holds the symbol under
  // the head; a head move rotates the ring by one place.
  logic [SYM_W-1:0] sym_w [TAPE_LEN];

  for (genvar i = 0; i < TAPE_LEN; i++) begin : g_cell
    tms_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl_i),
      .is_head_i    (i == 0),
      .from_left_i  (sym_w[(i + TAPE_LEN - 1) % TAPE_LEN]),
      .from_right_i (sym_w[(i + 1) % TAPE_LEN]),
      .sym_o        (sym_w[i])
    );
  end

  assign head_sym_o = sym_w[0];

endmodule

// ----- tb/sv/tb_turing_machine_step_top.sv -----
`timescale 1ns / 100ps

module tb_turing_machine_step_top;
  import tms_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_PHASES     = 8;

  // Request kind and move code that the package leaves unnamed.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [MOVE_W-1:0] MOVE_SPARE  = 2'd3;

  typedef struct packed {
    logic [SYM_W-1:0]  read_sym;
    logic [SYM_W-1:0]  written_sym;
    logic [OPOS_W-1:0] prior_pos;
    logic              ext_right;
    logic              ext_left;
    logic [OIDX_W-1:0] rule_idx;
    logic [ST_W-1:0]   new_st;
    logic              tape_clip;
  } step_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  sym;
    logic [ST_W-1:0]   st;
    logic [SYM_W-1:0]  wr;
    logic [MOVE_W-1:0] mv;
    logic [ST_W-1:0]   nx;
  } tm_request_t;

  typedef struct packed {
    tm_request_t  req;
    logic [15:0]  reps;
    logic         typed;
    step_result_t result;
  } directed_row_t;

  localparam step_result_t NO_RESULT = '0;

  // Directed requests, run after reset with one state in use and rule indexes reported.
  // Rows with a typed result are checked against that value; the rest against the predictor.
  directed_row_t directed_rows [0:17] = '{
    '{'{KIND_LOAD, 4'd0, 4'd0, 4'd15, MOVE_LEFT, 4'd15}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_LOAD, 4'd15, 4'd15, 4'd0, MOVE_RIGHT, 4'd0}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_STEP, 4'd0, 4'd0, 4'd0, MOVE_LEFT, 4'd0}, 16'd1, 1'b1,
      '{4'd0, 4'd15, 8'd128, 1'b0, 1'b1, 8'd0, 4'd15, 1'b0}},
    '{'{KIND_LOAD, 4'd0, 4'd15, 4'd3, MOVE_SPARE, 4'd1}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_STEP, 4'd15, 4'd15, 4'd15, MOVE_SPARE, 4'd15}, 16'd1, 1'b1,
      '{4'd0, 4'd3, 8'd127, 1'b0, 1'b0, 8'd15, 4'd1, 1'b0}},
    '{'{KIND_LOAD, 4'd3, 4'd1, 4'd9, MOVE_RIGHT, 4'd2}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_STEP, 4'd5, 4'd10, 4'd5, MOVE_STAY, 4'd10}, 16'd1, 1'b1,
      '{4'd3, 4'd9, 8'd127, 1'b0, 1'b0, 8'd4, 4'd2, 1'b0}},
    '{'{KIND_LOAD, 4'd15, 4'd2, 4'd5, MOVE_RIGHT, 4'd2}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_STEP, 4'd10, 4'd5, 4'd10, MOVE_RIGHT, 4'd5}, 16'd1, 1'b1,
      '{4'd15, 4'd5, 8'd128, 1'b1, 1'b0, 8'd17, 4'd2, 1'b0}},
    '{'{KIND_UNUSED, 4'd15, 4'd15, 4'd15, MOVE_SPARE, 4'd15}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_CLEAR, 4'd15, 4'd15, 4'd15, MOVE_SPARE, 4'd15}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_STEP, 4'd0, 4'd0, 4'd0, MOVE_LEFT, 4'd0}, 16'd1, 1'b1,
      '{4'd0, 4'd15, 8'd128, 1'b0, 1'b1, 8'd0, 4'd15, 1'b0}},
    '{'{KIND_LOAD, 4'd0, 4'd0, 4'd0, MOVE_RIGHT, 4'd0}, 16'd1, 1'b0, NO_RESULT},
    '{'{KIND_CLEAR, 4'd0, 4'd0, 4'd0, MOVE_LEFT, 4'd0}, 16'd1, 1'b0, NO_RESULT},
    // March the head into the right end of the tape and beyond.
    '{'{KIND_STEP, 4'd0, 4'd0, 4'd0, MOVE_LEFT, 4'd0}, 16'd130, 1'b0, NO_RESULT},
    '{'{KIND_LOAD, 4'd0, 4'd0, 4'd0, MOVE_LEFT, 4'd0}, 16'd1, 1'b0, NO_RESULT},
    // Then all the way back into the left end.
    '{'{KIND_STEP, 4'd0, 4'd0, 4'd0, MOVE_LEFT, 4'd0}, 16'd260, 1'b0, NO_RESULT},
    '{'{KIND_CLEAR, 4'd0, 4'd0, 4'd0, MOVE_LEFT, 4'd0}, 16'd1, 1'b0, NO_RESULT}
  };

  // Register settings of the random phases, extremes included.
  logic [CFG_DAT_W-1:0] phase_states [NUM_PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31,
                                                      5'd5, 5'd16, 5'd2, 5'd9};
  logic                 phase_detect [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                                      1'b1, 1'b0, 1'b0, 1'b1};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind;
  logic [SYM_W-1:0]     in_rule_symbol;
  logic [ST_W-1:0]      in_rule_state;
  logic [SYM_W-1:0]     in_rule_write;
  logic [MOVE_W-1:0]    in_rule_move;
  logic [ST_W-1:0]      in_rule_next;
  logic                 out_valid;
  logic                 out_ready;
  logic [SYM_W-1:0]     out_read_symbol;
  logic [SYM_W-1:0]     out_written_symbol;
  logic [OPOS_W-1:0]    out_prior_position;
  logic                 out_extended_right;
  logic                 out_extended_left;
  logic [OIDX_W-1:0]    out_rule_index;
  logic [ST_W-1:0]      out_new_state;
  logic                 out_tape_edge;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Machine copy kept by the predictor.
  logic [SYM_W-1:0]     tape_mem    [TAPE_LEN];
  logic [SYM_W-1:0]     rule_wr_mem [RULE_DEPTH];
  logic [MOVE_W-1:0]    rule_mv_mem [RULE_DEPTH];
  logic [ST_W-1:0]      rule_nx_mem [RULE_DEPTH];
  bit                   rule_loaded [RULE_DEPTH];
  int unsigned          head_pos;
  int unsigned          left_ext;
  int unsigned          right_ext;
  logic [ST_W-1:0]      cur_state;
  logic [CFG_DAT_W-1:0] num_states_cfg;
  logic                 detect_cycle_cfg;

  step_result_t pending_steps [$];
  int           fail_cnt;
  int           items_sent;
  int           quiet_cycles;
  bit           calm;

  turing_machine_step_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_rule_symbol     (in_rule_symbol),
    .in_rule_state      (in_rule_state),
    .in_rule_write      (in_rule_write),
    .in_rule_move       (in_rule_move),
    .in_rule_next       (in_rule_next),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_symbol    (out_read_symbol),
    .out_written_symbol (out_written_symbol),
    .out_prior_position (out_prior_position),
    .out_extended_right (out_extended_right),
    .out_extended_left  (out_extended_left),
    .out_rule_index     (out_rule_index),
    .out_new_state      (out_new_state),
    .out_tape_edge      (out_tape_edge),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) begin
      return 0;
    end
    if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic int unsigned rule_slot(input logic [SYM_W-1:0] sym,
                                            input logic [ST_W-1:0] st);
    return (32'(sym) * 32'(num_states_cfg) + 32'(st)) % RULE_DEPTH;
  endfunction

  function automatic void clear_machine();
    foreach (tape_mem[i]) begin
      tape_mem[i] = '0;
    end
    head_pos  = TAPE_LEN / 2;
    left_ext  = head_pos - 1;
    right_ext = head_pos + 1;
    cur_state = '0;
  endfunction

  // Applies one accepted request to the machine copy; returns 1 when a step result is due.
  function automatic bit advance_machine(input tm_request_t r, output step_result_t res);
    int unsigned       pos;
    int unsigned       np;
    int unsigned       idx;
    logic [MOVE_W-1:0] mv;
    bit                produced;
    produced = 1'b0;
    res = '0;
    case (r.kind)
      KIND_LOAD: begin
        idx = rule_slot(r.sym, r.st);
        rule_wr_mem[idx] = r.wr;
        rule_mv_mem[idx] = r.mv;
        rule_nx_mem[idx] = r.nx;
        rule_loaded[idx] = 1'b1;
      end
      KIND_CLEAR: begin
        clear_machine();
      end
      KIND_STEP: begin
        pos = head_pos;
        idx = rule_slot(tape_mem[pos], cur_state);
        mv  = rule_mv_mem[idx];
        np  = pos;
        res.read_sym    = tape_mem[pos];
        res.written_sym = rule_wr_mem[idx];
        res.prior_pos   = OPOS_W'(pos);
        tape_mem[pos]   = rule_wr_mem[idx];
        // Moves off either end are clipped; the spare code stays put.
        if (mv == MOVE_LEFT) begin
          if (pos == 0) res.tape_clip = 1'b1;
          else np = pos - 1;
        end else if (mv == MOVE_RIGHT) begin
          if (pos >= TAPE_LEN - 1) res.tape_clip = 1'b1;
          else np = pos + 1;
        end
        head_pos = np;
        // Only one extent can move per step; each saturates at its tape end.
        if (np >= right_ext) begin
          right_ext = (np + 1 < TAPE_LEN) ? np + 1 : TAPE_LEN - 1;
          res.ext_right = 1'b1;
        end else if (np <= left_ext) begin
          left_ext = (np > 0) ? np - 1 : 0;
          res.ext_left = 1'b1;
        end
        cur_state    = rule_nx_mem[idx];
        res.rule_idx = detect_cycle_cfg ? OIDX_W'(idx) : '0;
        res.new_st   = cur_state;
        produced     = 1'b1;
      end
      default: begin
      end
    endcase
    return produced;
  endfunction

  function automatic tm_request_t random_request(input logic [KIND_W-1:0] kind);
    tm_request_t r;
    r.kind = kind;
    r.sym  = SYM_W'($urandom);
    r.st   = ST_W'($urandom);
    r.wr   = SYM_W'($urandom);
    r.mv   = MOVE_W'($urandom);
    r.nx   = ST_W'($urandom);
    return r;
  endfunction

  // Presents one request after a random gap and holds it until it is taken.
  task automatic send_request(input tm_request_t r, input bit typed,
                              input step_result_t typed_res);
    int           gap;
    step_result_t res;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_kind        <= r.kind;
    in_rule_symbol <= r.sym;
    in_rule_state  <= r.st;
    in_rule_write  <= r.wr;
    in_rule_move   <= r.mv;
    in_rule_next   <= r.nx;
    do @(posedge clk); while (!in_ready);
    if (advance_machine(r, res)) begin
      pending_steps.insert(pending_steps.size(), typed ? typed_res : res);
    end
    if (r.kind != KIND_UNUSED) begin
      items_sent++;
    end
  endtask

  // A step that only ever reads a loaded rule: the rule under the head is
  // (re)loaded first when asked to or when it has never been written.
  task automatic run_step(input bit reload, input logic [MOVE_W-1:0] mv);
    tm_request_t r;
    r     = random_request(KIND_LOAD);
    r.sym = tape_mem[head_pos];
    r.st  = cur_state;
    r.mv  = mv;
    if (reload || !rule_loaded[rule_slot(r.sym, r.st)]) begin
      send_request(r, 1'b0, NO_RESULT);
    end
    send_request(random_request(KIND_STEP), 1'b0, NO_RESULT);
  endtask

  // Drops the request line and lets every outstanding step drain.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DAT_W-1:0] states, input logic detect);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_STATES;
    cfg_data  <= states;
    @(negedge clk);
    cfg_index <= CFG_DETECT_CYCLE;
    cfg_data  <= CFG_DAT_W'(detect);
    @(negedge clk);
    cfg_we <= 1'b0;
    num_states_cfg   = states;
    detect_cycle_cfg = detect;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Result side: random back-pressure.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      gap = idle_len();
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  // Each step result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    step_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $error("step result with no request outstanding");
        fail_cnt++;
      end else begin
        want = pending_steps.pop_front();
        check_field("read_symbol", 32'(want.read_sym), 32'(out_read_symbol));
        check_field("written_symbol", 32'(want.written_sym), 32'(out_written_symbol));
        check_field("prior_position", 32'(want.prior_pos), 32'(out_prior_position));
        check_field("extended_right", 32'(want.ext_right), 32'(out_extended_right));
        check_field("extended_left", 32'(want.ext_left), 32'(out_extended_left));
        check_field("rule_index", 32'(want.rule_idx), 32'(out_rule_index));
        check_field("new_state", 32'(want.new_st), 32'(out_new_state));
        check_field("tape_edge", 32'(want.tape_clip), 32'(out_tape_edge));
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int                start_items;
    int                steps;
    int                pick;
    logic [MOVE_W-1:0] dir;
    directed_row_t     row;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_LOAD;
    in_rule_symbol = '0;
    in_rule_state  = '0;
    in_rule_write  = '0;
    in_rule_move   = MOVE_LEFT;
    in_rule_next   = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_NUM_STATES;
    cfg_data       = '0;
    items_sent     = 0;
    calm           = 1'b0;

    // Machine copy as after reset.
    foreach (rule_loaded[i]) begin
      rule_wr_mem[i] = '0;
      rule_mv_mem[i] = MOVE_LEFT;
      rule_nx_mem[i] = '0;
      rule_loaded[i] = 1'b0;
    end
    clear_machine();
    num_states_cfg   = 5'd1;
    detect_cycle_cfg = 1'b1;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      repeat (row.reps) send_request(row.req, row.typed, row.result);
    end

    // Random phases, one register setting each; some phases run without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_config(phase_states[p], phase_detect[p]);
      calm = (p % 3 == 2);
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS / NUM_PHASES) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            // Drift: steps biased one way, now and then a long run.
            dir   = $urandom_range(0, 1) ? MOVE_RIGHT : MOVE_LEFT;
            steps = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(5, 40);
            repeat (steps) begin
              if (items_sent - start_items >= RANDOM_ITEMS / NUM_PHASES) break;
              run_step($urandom_range(0, 4) != 0,
                       ($urandom_range(0, 7) == 0) ? MOVE_W'($urandom) : dir);
            end
          end
          default: begin
            // Mixed traffic: steps, stray loads, clears and unused kinds.
            repeat ($urandom_range(10, 40)) begin
              if (items_sent - start_items >= RANDOM_ITEMS / NUM_PHASES) break;
              pick = $urandom_range(0, 99);
              if (pick < 45) begin
                run_step($urandom_range(0, 2) == 0, MOVE_W'($urandom));
              end else if (pick < 75) begin
                send_request(random_request(KIND_LOAD), 1'b0, NO_RESULT);
              end else if (pick < 88) begin
                send_request(random_request(KIND_CLEAR), 1'b0, NO_RESULT);
              end else begin
                send_request(random_request(KIND_UNUSED), 1'b0, NO_RESULT);
              end
            end
          end
        endcase
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
